@@ sv/vwt_pkg.sv @@
// Shared types and constants for the vertex weld table.
`default_nettype none
package vwt_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int LIMIT_W    = 34;
  localparam int INDEX_W    = 10;
  localparam int MAX_POINTS_DEFAULT = 1024;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(268);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage
`default_nettype wire

@@ sv/vwt_point_mem.sv @@
// Point store: single-port-write, single-port-read synchronous memory.
`default_nettype none
module vwt_point_mem
  import vwt_pkg::*;
#(
  parameter int DEPTH = MAX_POINTS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire point_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output point_t             rd_data
);

  point_t mem [DEPTH];

  // Write new points
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/vwt_dist.sv @@
// Distance pipeline: squares the coordinate differences and compares against the limit.
`default_nettype none
module vwt_dist
  import vwt_pkg::*;
#(
  parameter int AW = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               flush,
  input  wire logic               issue_valid,
  input  wire logic [AW-1:0]      issue_index,
  input  wire point_t             rd_data,
  input  wire point_t             query,
  input  wire logic [LIMIT_W-1:0] limit,
  output logic                    hit_valid,
  output logic                    hit,
  output logic [AW-1:0]           hit_index
);

  logic              rd_valid;
  logic [AW-1:0]     rd_index;
  logic              sq_valid;
  logic [AW-1:0]     sq_index;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  logic [SQ_W-1:0]   sq_z;
  logic [MAG_W-1:0]  mag_x;
  logic [MAG_W-1:0]  mag_y;
  logic [MAG_W-1:0]  mag_z;
  logic [LIMIT_W-1:0] sq_sum;

  function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                input logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] m;
    d = DIFF_W'(a) - DIFF_W'(b);
    m = d[DIFF_W-1] ? -d : d;
    return m[MAG_W-1:0];
  endfunction

  // Coordinate magnitudes of the stored point against the query, and the sum of their squares
  always_comb begin
    mag_x  = abs_diff(rd_data.x, query.x);
    mag_y  = abs_diff(rd_data.y, query.y);
    mag_z  = abs_diff(rd_data.z, query.z);
    sq_sum = LIMIT_W'(sq_x) + LIMIT_W'(sq_y) + LIMIT_W'(sq_z);
  end

  // Advance valid tags; drop everything in flight on flush
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      rd_valid  <= 1'b0;
      sq_valid  <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      rd_valid  <= issue_valid;
      sq_valid  <= rd_valid;
      hit_valid <= sq_valid;
    end
  end

  // Payload stages: square, then sum and compare
  always_ff @(posedge clk) begin
    rd_index  <= issue_index;
    sq_index  <= rd_index;
    sq_x      <= SQ_W'(mag_x) * SQ_W'(mag_x);
    sq_y      <= SQ_W'(mag_y) * SQ_W'(mag_y);
    sq_z      <= SQ_W'(mag_z) * SQ_W'(mag_z);
    hit_index <= sq_index;
    hit       <= (sq_sum < limit);
  end

endmodule
`default_nettype wire

@@ sv/vertex_weld_table_core.sv @@
// Top level of the vertex weld table: request sequencer, point store and distance pipeline.
//
// Usage:
//   Raise start with op and x/y/z_coord; the transaction is taken at an edge where
//   busy is low. op clear empties the table; op look-up scans the stored points in
//   insertion order and returns the first one closer than the configured limit, or
//   appends the point, or flags table_full when no room remains.
//   Every transaction gives one result, shown for one cycle with result_valid high;
//   the receiver cannot stall, so no result is ever held back.
//   A clear returns its result in the cycle after acceptance.
//   A look-up reads one stored point per cycle from the point memory; this read
//   port sets the rate. busy stays high until a match is found or every stored
//   point has been compared, and the result follows in the next cycle.
//   cfg_write_en with cfg_write_data sets the squared match limit (unsigned Q34.0); write it
//   only while the block is idle.
//   Reset empties the table and loads the default limit; the store needs no
//   clearing pass since only entries below the fill count are ever read.
`default_nettype none
module vertex_weld_table_core
  import vwt_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       op,
  input  wire logic signed [COORD_W-1:0]  x_coord,
  input  wire logic signed [COORD_W-1:0]  y_coord,
  input  wire logic signed [COORD_W-1:0]  z_coord,
  input  wire logic                       cfg_write_en,
  input  wire logic [LIMIT_W-1:0]         cfg_write_data,
  output logic                            result_valid,
  output logic [INDEX_W-1:0]              vertex_index,
  output logic                            was_inserted,
  output logic                            table_full
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [LIMIT_W-1:0] limit;
  point_t             query;
  logic [AW-1:0]      rd_addr;
  logic               all_issued;
  logic               rd_en;
  logic               accept;
  logic               is_full;
  logic               miss_done;
  logic               match_done;
  logic               finish;
  logic               wr_en;
  logic [AW-1:0]      last_idx;
  point_t             rd_data;
  logic               hit_valid;
  logic               hit;
  logic [AW-1:0]      hit_index;

  // Scan control
  always_comb begin
    busy       = (state != ST_IDLE);
    accept     = start && !busy;
    rd_en      = (state == ST_SCAN) && !all_issued && (count != '0);
    last_idx   = AW'(count - CW'(1));
    is_full    = (count == CW'(MAX_POINTS));
    match_done = (state == ST_SCAN) && hit_valid && hit;
    miss_done  = (state == ST_SCAN) &&
                 ((count == '0) || (hit_valid && !hit && (hit_index == last_idx)));
    finish     = match_done || miss_done;
    wr_en      = miss_done && !match_done && !is_full;
  end

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      limit <= cfg_write_data;
    end
  end

  // Hold the query point for the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      query <= '{x: x_coord, y: y_coord, z: z_coord};
    end
  end

  // Sequencer: state, fill count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      rd_addr      <= '0;
      all_issued   <= 1'b0;
      result_valid <= 1'b0;
      vertex_index <= '0;
      was_inserted <= 1'b0;
      table_full   <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_addr    <= '0;
            all_issued <= 1'b0;
            if (op == OP_CLEAR) begin
              count        <= '0;
              result_valid <= 1'b1;
              vertex_index <= '0;
              was_inserted <= 1'b0;
              table_full   <= 1'b0;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle until every stored point is requested
          if (rd_en) begin
            rd_addr <= rd_addr + AW'(1);
            if (CW'(rd_addr) + CW'(1) == count) begin
              all_issued <= 1'b1;
            end
          end
          if (match_done) begin
            state        <= ST_IDLE;
            result_valid <= 1'b1;
            vertex_index <= INDEX_W'(hit_index);
            was_inserted <= 1'b0;
            table_full   <= 1'b0;
          end else if (miss_done) begin
            state        <= ST_IDLE;
            result_valid <= 1'b1;
            if (is_full) begin
              vertex_index <= '0;
              was_inserted <= 1'b0;
              table_full   <= 1'b1;
            end else begin
              vertex_index <= INDEX_W'(count);
              was_inserted <= 1'b1;
              table_full   <= 1'b0;
              count        <= count + CW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  vwt_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count)),
    .wr_data (query),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vwt_dist #(
    .AW (AW)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .flush       (finish),
    .issue_valid (rd_en),
    .issue_index (rd_addr),
    .rd_data     (rd_data),
    .query       (query),
    .limit       (limit),
    .hit_valid   (hit_valid),
    .hit         (hit),
    .hit_index   (hit_index)
  );

endmodule
`default_nettype wire

@@ tb/vwt_checker.sv @@
// Checker for the vertex weld table: watches the ports, predicts each result and compares.
`timescale 1ns / 100ps
module vwt_checker
  import vwt_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       op,
  input  logic signed [COORD_W-1:0]  x_coord,
  input  logic signed [COORD_W-1:0]  y_coord,
  input  logic signed [COORD_W-1:0]  z_coord,
  input  logic                       cfg_write_en,
  input  logic [LIMIT_W-1:0]         cfg_write_data,
  input  logic                       result_valid,
  input  logic [INDEX_W-1:0]         vertex_index,
  input  logic                       was_inserted,
  input  logic                       table_full,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               inserted;
    logic               full;
  } weld_result_t;

  point_t             welded_points [MAX_POINTS];
  int unsigned        welded_total;
  logic [LIMIT_W-1:0] weld_limit;
  weld_result_t       expected_welds [$];

  function automatic longint unsigned gap_squared(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    longint gap;
    gap = longint'(a) - longint'(b);
    return longint'(gap * gap);
  endfunction

  // Apply one transaction to the shadow table and return its result.
  function automatic weld_result_t weld_point(logic req_op, point_t req);
    weld_result_t     res;
    longint unsigned  sq_dist;
    res = '0;
    if (req_op == OP_CLEAR) begin
      welded_total = 0;
      return res;
    end
    // First stored point strictly inside the limit wins
    for (int unsigned i = 0; i < welded_total; i++) begin
      sq_dist = gap_squared(welded_points[i].x, req.x)
              + gap_squared(welded_points[i].y, req.y)
              + gap_squared(welded_points[i].z, req.z);
      if (sq_dist < longint'(weld_limit)) begin
        res.index = INDEX_W'(i);
        return res;
      end
    end
    if (welded_total >= MAX_POINTS) begin
      res.full = 1'b1;
      return res;
    end
    welded_points[welded_total] = req;
    res.index    = INDEX_W'(welded_total);
    res.inserted = 1'b1;
    welded_total++;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    weld_result_t want;
    point_t       req;
    if (rst) begin
      expected_welds.delete();
      welded_total = 0;
      weld_limit   = LIMIT_RESET;
      fail_count   = 0;
    end else begin
      // Compare the result on the bus with the oldest outstanding transaction
      if (result_valid) begin
        if (expected_welds.size() == 0) begin
          report_mismatch($sformatf("result with no transaction outstanding, index %0d",
                                    vertex_index));
        end else begin
          want = expected_welds.pop_front();
          if (vertex_index !== want.index)
            report_mismatch($sformatf("vertex_index got %0d, expected %0d",
                                      vertex_index, want.index));
          if (was_inserted !== want.inserted)
            report_mismatch($sformatf("was_inserted got %0b, expected %0b",
                                      was_inserted, want.inserted));
          if (table_full !== want.full)
            report_mismatch($sformatf("table_full got %0b, expected %0b",
                                      table_full, want.full));
        end
      end
      if (cfg_write_en) begin
        weld_limit = cfg_write_data;
      end
      // Predict each accepted transaction
      if (start && !busy) begin
        req.x = x_coord;
        req.y = y_coord;
        req.z = z_coord;
        expected_welds.insert(expected_welds.size(), weld_point(op, req));
      end
    end
    pending = expected_welds.size();
  end

endmodule

@@ tb/tb_vertex_weld_table_core.sv @@
// Testbench top for the vertex weld table: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_vertex_weld_table_core;
  import vwt_pkg::*;

  localparam int TABLE_DEPTH    = MAX_POINTS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [LIMIT_W-1:0] LIMIT_ALL_ONES = '1;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      op = OP_LOOKUP;
  logic signed [COORD_W-1:0] x_coord = '0;
  logic signed [COORD_W-1:0] y_coord = '0;
  logic signed [COORD_W-1:0] z_coord = '0;
  logic                      cfg_write_en = 1'b0;
  logic [LIMIT_W-1:0]        cfg_write_data = '0;
  logic                      result_valid;
  logic [INDEX_W-1:0]        vertex_index;
  logic                      was_inserted;
  logic                      table_full;
  int                        fail_count;
  int                        pending;
  int                        idle_cycles = 0;
  point_t                    sent_points [$];

  always #5 clk = ~clk;

  vertex_weld_table_core #(
    .MAX_POINTS(TABLE_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .z_coord       (z_coord),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .result_valid  (result_valid),
    .vertex_index  (vertex_index),
    .was_inserted  (was_inserted),
    .table_full    (table_full)
  );

  vwt_checker #(
    .MAX_POINTS(TABLE_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .z_coord       (z_coord),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .result_valid  (result_valid),
    .vertex_index  (vertex_index),
    .was_inserted  (was_inserted),
    .table_full    (table_full),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Stop the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic point_t make_point(int a, int b, int c);
    point_t p;
    p.x = COORD_W'(a);
    p.y = COORD_W'(b);
    p.z = COORD_W'(c);
    return p;
  endfunction

  // Lean toward the coordinate extremes
  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.x = random_coord();
    p.y = random_coord();
    p.z = random_coord();
    return p;
  endfunction

  // Drive one transaction and hold it until the block takes it; returns on a falling edge
  task automatic send_item(input logic req_op, input point_t p);
    op      <= req_op;
    x_coord <= p.x;
    y_coord <= p.y;
    z_coord <= p.z;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_after(input int idle_pct);
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Mostly points near earlier ones so that matches happen, with clears and noise mixed in
  task automatic random_phase(input int count, input int idle_pct, input int span);
    point_t p;
    point_t base;
    int     pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3 || (sent_points.size() >= 60 && $urandom_range(0, 3) == 0)) begin
        send_item(OP_CLEAR, random_point());
        sent_points.delete();
      end else begin
        if (sent_points.size() == 0 || pick >= 70) begin
          p = random_point();
        end else begin
          base = sent_points[$urandom_range(0, sent_points.size() - 1)];
          p = base;
          if (pick >= 13) begin
            p.x = COORD_W'(int'(base.x) + int'($urandom_range(0, 2 * span)) - span);
            p.y = COORD_W'(int'(base.y) + int'($urandom_range(0, 2 * span)) - span);
            p.z = COORD_W'(int'(base.z) + int'($urandom_range(0, 2 * span)) - span);
          end
        end
        send_item(OP_LOOKUP, p);
        sent_points.insert(sent_points.size(), p);
      end
      idle_after(idle_pct);
      if ($urandom_range(0, 99) < 3) begin
        drain();
      end
    end
  endtask

  initial begin
    int                 k;
    logic [LIMIT_W-1:0] limit_value;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default limit: extremes, exact limit distance, first match wins, clear
    send_item(OP_CLEAR, make_point(-1, -1, -1));
    send_item(OP_LOOKUP, make_point(-32768, -32768, -32768));
    send_item(OP_LOOKUP, make_point(32767, 32767, 32767));
    send_item(OP_LOOKUP, make_point(0, 0, 0));
    send_item(OP_LOOKUP, make_point(14, 6, 6));
    send_item(OP_LOOKUP, make_point(14, 6, 5));
    send_item(OP_LOOKUP, make_point(-32768, -32768, -32768));
    send_item(OP_LOOKUP, make_point(32767, -32768, 0));
    send_item(OP_CLEAR, make_point(32767, 32767, 32767));
    send_item(OP_LOOKUP, make_point(5, 5, 5));

    // Largest limit: opposite corners still match
    write_limit(LIMIT_ALL_ONES);
    send_item(OP_CLEAR, make_point(0, 0, 0));
    send_item(OP_LOOKUP, make_point(-32768, -32768, -32768));
    send_item(OP_LOOKUP, make_point(32767, 32767, 32767));
    send_item(OP_LOOKUP, make_point(-1, 0, 1));

    // Zero limit: even the same point never matches
    write_limit('0);
    send_item(OP_CLEAR, make_point(0, 0, 0));
    send_item(OP_LOOKUP, make_point(7, -7, 7));
    send_item(OP_LOOKUP, make_point(7, -7, 7));

    // Random phases with several limits and sender idling
    write_limit(LIMIT_RESET);
    sent_points.delete();
    random_phase(140, 0, 12);

    write_limit(LIMIT_W'(1) << 20);
    random_phase(140, 77, 1500);

    k = $urandom_range(6, 32);
    limit_value = (LIMIT_W'($urandom()) & ((LIMIT_W'(1) << k) - 1)) | (LIMIT_W'(1) << (k - 1));
    write_limit(limit_value);
    random_phase(140, 0, 1 << (k / 2));

    write_limit(LIMIT_W'(1) << 26);
    random_phase(140, 28, 12000);

    // Let the last results come back
    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
